FILE: rtl/rtmc_pkg.sv
// Shared types, command and status codes for the region table block.
package rtmc_pkg;

	localparam int unsigned CAPACITY_DEF = 64;

	localparam logic [1:0] CMD_ADD     = 2'd0;
	localparam logic [1:0] CMD_MARK    = 2'd1;
	localparam logic [1:0] CMD_COMPACT = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_NOMATCH = 2'd2;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        atomic;
	} rtmc_entry_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] entry_count;
		logic [5:0] slot;
	} rtmc_res_t;

endpackage

FILE: rtl/rtmc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module rtmc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/rtmc_engine.sv
// Command sequencer that reads, modifies and writes back the region table RAM.
module rtmc_engine
	import rtmc_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  command,
	input  logic [31:0] region_start,
	input  logic [31:0] region_size,
	input  logic        atomic_mark,
	output logic        res_valid,
	input  logic        res_ready,
	output rtmc_res_t   res
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_PACK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_q;
	logic [CW-1:0] kept_q;
	logic          chk_vld_s1;
	logic [IW-1:0] chk_idx_s1;
	logic [31:0]   start_q;
	rtmc_res_t     res_q;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	rtmc_entry_t   wr_data;
	rtmc_entry_t   rd_data;
	logic          hit;
	logic          keep;
	logic [CW-1:0] kept_nx;
	logic          room;

	function automatic logic [6:0] sat_count(input logic [CW-1:0] v);
		if (32'(v) > 32'd127) begin
			return 7'd127;
		end
		return 7'(v);
	endfunction

	function automatic logic [5:0] sat_slot(input logic [CW-1:0] v);
		if (32'(v) > 32'd63) begin
			return 6'd63;
		end
		return 6'(v);
	endfunction

	rtmc_ram #(
		.WIDTH($bits(rtmc_entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (issue_q[IW-1:0]),
		.rd_data (rd_data)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign room    = (count_q < CW'(CAPACITY));
	assign hit     = chk_vld_s1 && (rd_data.start == start_q);
	assign keep    = chk_vld_s1 && ((rd_data.start != '0) || (rd_data.size != '0));
	assign kept_nx = kept_q + CW'(keep);

	// Write port: append on add, clear on a mark hit, move a kept entry down on compact.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IW-1:0];
		wr_data = '{start: region_start, size: region_size, atomic: atomic_mark};
		unique case (state_q)
			S_IDLE: begin
				wr_en = cmd_valid && (command == CMD_ADD) && room;
			end
			S_SCAN: begin
				wr_en   = hit;
				wr_addr = chk_idx_s1;
				wr_data = '{start: 32'd0, size: 32'd0, atomic: rd_data.atomic};
			end
			S_PACK: begin
				wr_en   = keep;
				wr_addr = kept_q[IW-1:0];
				wr_data = rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			issue_q    <= '0;
			kept_q     <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						issue_q    <= '0;
						kept_q     <= '0;
						chk_vld_s1 <= 1'b0;
						case (command)
							CMD_ADD: begin
								if (room) begin
									count_q <= CW'(count_q + 1'b1);
								end
								state_q <= S_DONE;
							end
							CMD_MARK:    state_q <= S_SCAN;
							CMD_COMPACT: state_q <= S_PACK;
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (hit || (issue_q == count_q)) begin
						state_q    <= S_DONE;
						chk_vld_s1 <= 1'b0;
					end else begin
						issue_q    <= CW'(issue_q + 1'b1);
						chk_vld_s1 <= 1'b1;
					end
				end
				S_PACK: begin
					kept_q <= kept_nx;
					if (issue_q == count_q) begin
						count_q    <= kept_nx;
						state_q    <= S_DONE;
						chk_vld_s1 <= 1'b0;
					end else begin
						issue_q    <= CW'(issue_q + 1'b1);
						chk_vld_s1 <= 1'b1;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				start_q <= region_start;
				case (command)
					CMD_ADD: begin
						if (room) begin
							res_q <= '{status: STAT_OK,
								entry_count: sat_count(CW'(count_q + 1'b1)),
								slot: sat_slot(count_q)};
						end else begin
							res_q <= '{status: STAT_FULL, entry_count: sat_count(count_q),
								slot: 6'd0};
						end
					end
					default: begin
						res_q <= '{status: STAT_OK, entry_count: sat_count(count_q),
							slot: 6'd0};
					end
				endcase
			end
			S_SCAN: begin
				chk_idx_s1 <= issue_q[IW-1:0];
				if (hit) begin
					res_q <= '{status: STAT_OK, entry_count: sat_count(count_q),
						slot: sat_slot(CW'(chk_idx_s1))};
				end else if (issue_q == count_q) begin
					res_q <= '{status: STAT_NOMATCH, entry_count: sat_count(count_q),
						slot: 6'd0};
				end
			end
			S_PACK: begin
				chk_idx_s1 <= issue_q[IW-1:0];
				if (issue_q == count_q) begin
					res_q <= '{status: STAT_OK, entry_count: sat_count(kept_nx),
						slot: sat_slot(CW'(count_q - kept_nx))};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/region_table_mark_compact.sv
// Top level of the region table with add, mark and compact commands.
//
// Usage: command words arrive on the cmd channel (cmd_valid / cmd_ready) with the
// fields command, region_start, region_size and atomic_mark. Every command word
// yields exactly one result word on the res channel (res_valid / res_ready) with
// status, entry_count and slot. Words are handled one at a time, in order.
//
// Sequencing: an add, a rejected add or an unused command code moves from
// acceptance straight to the done state and gives its result from there. A mark
// walks the table from entry zero through the one RAM read port, one entry a
// cycle, and stops at the first match or after the last entry in use. A compact
// walks every entry in use once. The next command word is taken in the cycle
// after the engine hands its result on.
//
// Reset clears the entry count and all control state at once; the table RAM is
// not cleared, since only entries below the count are ever read.
//
// When the receiver stalls, the finished result waits in the output register. The
// engine still accepts and finishes one further command word, then holds that
// result and keeps cmd_ready low until the output register drains.
module region_table_mark_compact
	import rtmc_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  command,
	input  logic [31:0] region_start,
	input  logic [31:0] region_size,
	input  logic        atomic_mark,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  status,
	output logic [6:0]  entry_count,
	output logic [5:0]  slot
);

	logic      eng_valid;
	logic      eng_ready;
	rtmc_res_t eng_res;
	logic      out_valid_q;
	rtmc_res_t out_q;

	rtmc_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.command      (command),
		.region_start (region_start),
		.region_size  (region_size),
		.atomic_mark  (atomic_mark),
		.res_valid    (eng_valid),
		.res_ready    (eng_ready),
		.res          (eng_res)
	);

	// The output register takes a new result whenever it is empty or being emptied.
	assign eng_ready = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_ready) begin
			out_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_ready && eng_valid) begin
			out_q <= eng_res;
		end
	end

	assign res_valid   = out_valid_q;
	assign status      = out_q.status;
	assign entry_count = out_q.entry_count;
	assign slot        = out_q.slot;

	// The reported count can never pass the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (32'(entry_count) <= CAPACITY))
		else $error("entry count above capacity");

	// An add is only refused when the table is exactly full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (status == STAT_FULL)) |->
		((CAPACITY > 127) || (32'(entry_count) == CAPACITY)))
		else $error("full reported with table not full");

	// A refused add or a failed mark reports slot zero.
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (status != STAT_OK)) |-> (slot == 6'd0))
		else $error("non-zero slot on failed command");

	// The engine never takes a command word while it is still walking the table.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted back to back");

endmodule
